// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/sws_pkg.sv =====
package sws_pkg;

  localparam int VW  = 12;
  localparam int JW  = 8;
  localparam int WW  = 16;
  localparam int OJW = 9;
  localparam int SLW = 2;
  localparam int OVW = 24;

  localparam int VERTICES_DEF = 4096;
  localparam int JOINTS_DEF   = 256;
  localparam int KEEP_DEF     = 4;

  localparam logic [OVW-1:0] OVF_MAX = '1;
  localparam logic [WW-1:0]  W_MAX   = '1;
  localparam logic signed [OJW-1:0] JOINT_EMPTY = '1;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic          operation;
    logic [VW-1:0] vertex_index;
    logic [JW-1:0] joint_index;
    logic [WW-1:0] weight;
  } item_t;

  typedef struct packed {
    logic          load;
    logic [VW-1:0] vertex;
  } buf_ctl_t;

  function automatic int fill_width(input int keep);
    return $clog2(keep + 1);
  endfunction

  function automatic int entry_width(input int keep);
    return keep * (JW + WW) + fill_width(keep) + OVW;
  endfunction

endpackage

// ===== rtl/sws_ram.sv =====
module sws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sws_update.sv =====
module sws_update #(
  parameter int VERTICES = 4096,
  parameter int JOINTS   = 256,
  parameter int KEEP     = 4,
  parameter int EW       = 104
) (
  input  sws_pkg::item_t                  item,
  input  logic [EW-1:0]                   rd_entry,
  output logic                            wr_en,
  output logic [EW-1:0]                   wr_entry,
  output logic signed [sws_pkg::OJW-1:0]  row_joint [KEEP],
  output logic [sws_pkg::WW-1:0]          row_weight [KEEP]
);
  import sws_pkg::*;

  localparam int FW  = fill_width(KEEP);
  localparam int L   = $clog2(KEEP);
  localparam int MW  = OVW + L + 1;
  localparam int PW  = OVW + MW;
  localparam int OSW = OVW + 1;
  localparam int WB  = KEEP * JW;
  localparam int FB  = KEEP * (JW + WW);
  localparam int OB  = FB + FW;
  localparam longint RECIP_L =
    ((longint'(1) << (OVW + L)) + longint'(KEEP) - longint'(1)) / longint'(KEEP);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic [JW-1:0]   cur_j [KEEP];
  logic [WW-1:0]   cur_w [KEEP];
  logic [JW-1:0]   new_j [KEEP];
  logic [WW-1:0]   new_w [KEEP];
  logic [OSW-1:0]  sum_w [KEEP];
  logic [FW-1:0]   cur_fill;
  logic [FW-1:0]   fill_c;
  logic [FW-1:0]   fill_k;
  logic [FW-1:0]   new_fill;
  logic [FW-1:0]   pos;
  logic [KEEP-1:0] ge;
  logic            full;
  logic [OVW-1:0]  ovf;
  logic [WW-1:0]   ovf_add;
  logic [OSW-1:0]  ovf_sum;
  logic [OVW-1:0]  new_ovf;
  logic [PW-1:0]   prod;
  logic [OVW-1:0]  quarter;
  logic            vertex_ok;
  logic            joint_ok;

  assign vertex_ok = 32'(item.vertex_index) < VERTICES;
  assign joint_ok  = 32'(item.joint_index) < JOINTS;

  // insertion into the sorted list
  always_comb begin
    for (int k = 0; k < KEEP; k++) begin
      cur_j[k] = rd_entry[k*JW +: JW];
      cur_w[k] = rd_entry[WB + k*WW +: WW];
    end
    cur_fill = rd_entry[FB +: FW];
    ovf      = rd_entry[OB +: OVW];
    fill_c   = (cur_fill > FW'(KEEP)) ? FW'(KEEP) : cur_fill;

    pos = '0;
    for (int k = 0; k < KEEP; k++) begin
      ge[k] = (FW'(k) < fill_c) && (cur_w[k] >= item.weight);
      pos   = pos + FW'(ge[k]);
    end
    full = fill_c == FW'(KEEP);

    ovf_add = '0;
    fill_k  = fill_c;
    if (pos == FW'(KEEP)) begin
      ovf_add = item.weight;
    end else if (full) begin
      ovf_add = cur_w[KEEP-1];
      fill_k  = FW'(KEEP - 1);
    end
    ovf_sum = {1'b0, ovf} + OSW'(ovf_add);
    new_ovf = ovf_sum[OVW] ? OVF_MAX : ovf_sum[OVW-1:0];

    new_j    = cur_j;
    new_w    = cur_w;
    new_fill = fill_c;
    if (pos != FW'(KEEP)) begin
      for (int k = 0; k < KEEP; k++) begin
        if (FW'(k) == pos) begin
          new_j[k] = item.joint_index;
          new_w[k] = item.weight;
        end
      end
      for (int k = 1; k < KEEP; k++) begin
        if (FW'(k) > pos && FW'(k) <= fill_k) begin
          new_j[k] = cur_j[k-1];
          new_w[k] = cur_w[k-1];
        end
      end
      new_fill = fill_k + FW'(1);
    end
  end

  // write-back word
  always_comb begin
    wr_entry = '0;
    if (item.operation == OP_ADD) begin
      for (int k = 0; k < KEEP; k++) begin
        wr_entry[k*JW +: JW]      = new_j[k];
        wr_entry[WB + k*WW +: WW] = new_w[k];
      end
      wr_entry[FB +: FW]  = new_fill;
      wr_entry[OB +: OVW] = new_ovf;
      wr_en = vertex_ok && joint_ok;
    end else begin
      wr_en = vertex_ok;
    end
  end

  // readout row, overflow share by reciprocal multiply
  assign prod    = PW'(ovf) * PW'(RECIP);
  assign quarter = prod[OVW + L +: OVW];

  always_comb begin
    for (int k = 0; k < KEEP; k++) begin
      sum_w[k] = OSW'(cur_w[k]) + OSW'(quarter);
      if (vertex_ok && FW'(k) < fill_c) begin
        row_joint[k]  = signed'({1'b0, cur_j[k]});
        row_weight[k] = (sum_w[k] > OSW'(W_MAX)) ? W_MAX : sum_w[k][WW-1:0];
      end else begin
        row_joint[k]  = JOINT_EMPTY;
        row_weight[k] = '0;
      end
    end
  end

endmodule

// ===== rtl/sws_outbuf.sv =====
module sws_outbuf #(
  parameter int KEEP = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sws_pkg::buf_ctl_t               ctl,
  input  logic signed [sws_pkg::OJW-1:0]  row_joint [KEEP],
  input  logic [sws_pkg::WW-1:0]          row_weight [KEEP],
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [sws_pkg::VW-1:0]          out_vertex,
  output logic [sws_pkg::SLW-1:0]         slot,
  output logic signed [sws_pkg::OJW-1:0]  out_joint,
  output logic [sws_pkg::WW-1:0]          out_weight,
  output logic                            last
);
  import sws_pkg::*;

  localparam int IW = (KEEP > 1) ? $clog2(KEEP) : 1;

  logic                  busy;
  logic [IW-1:0]         idx;
  logic [VW-1:0]         vertex;
  logic signed [OJW-1:0] joints [KEEP];
  logic [WW-1:0]         weights [KEEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (ctl.load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      if (idx == IW'(KEEP - 1)) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vertex  <= ctl.vertex;
      joints  <= row_joint;
      weights <= row_weight;
    end
  end

  assign out_valid  = busy;
  assign out_vertex = vertex;
  assign slot       = SLW'(idx);
  assign out_joint  = joints[idx];
  assign out_weight = weights[idx];
  assign last       = idx == IW'(KEEP - 1);

endmodule

// ===== rtl/skin_weight_top4_select.sv =====
// an add word is taken, then read-modify-written in the next cycle
// input: in_ready holds off a new word until the memory write-back of the last one
// readout: row read, loaded into the output buffer, then KEEP words at one per cycle
//   with out_ready; adds go on, a further readout waits for the output register to drain
// reset: synchronous; a clearing pass writes every entry, input held off
module skin_weight_top4_select #(
  parameter int VERTICES = sws_pkg::VERTICES_DEF,
  parameter int JOINTS   = sws_pkg::JOINTS_DEF,
  parameter int KEEP     = sws_pkg::KEEP_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [sws_pkg::VW-1:0]          vertex_index,
  input  logic [sws_pkg::JW-1:0]          joint_index,
  input  logic [sws_pkg::WW-1:0]          weight,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sws_pkg::VW-1:0]          out_vertex,
  output logic [sws_pkg::SLW-1:0]         slot,
  output logic signed [sws_pkg::OJW-1:0]  out_joint,
  output logic [sws_pkg::WW-1:0]          out_weight,
  output logic                            last
);
  import sws_pkg::*;

  localparam int EW = entry_width(KEEP);
  localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  item_t           item_q;
  logic            accept;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;
  logic            upd_wr_en;
  logic [EW-1:0]   upd_wr_entry;
  logic signed [OJW-1:0] row_joint [KEEP];
  logic [WW-1:0]   row_weight [KEEP];
  buf_ctl_t        buf_ctl;

  assign in_ready = (state == S_IDLE) && (operation == OP_ADD || !out_valid);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(VERTICES - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= '{operation: operation, vertex_index: vertex_index,
                  joint_index: joint_index, weight: weight};
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_EXEC) && upd_wr_en;
      ram_waddr = AW'(item_q.vertex_index);
      ram_wdata = upd_wr_entry;
    end
  end

  assign buf_ctl.load   = (state == S_EXEC) && (item_q.operation == OP_READ);
  assign buf_ctl.vertex = item_q.vertex_index;

  sws_ram #(
    .WIDTH (EW),
    .DEPTH (VERTICES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (AW'(vertex_index)),
    .rdata (ram_rdata)
  );

  sws_update #(
    .VERTICES (VERTICES),
    .JOINTS   (JOINTS),
    .KEEP     (KEEP),
    .EW       (EW)
  ) u_update (
    .item       (item_q),
    .rd_entry   (ram_rdata),
    .wr_en      (upd_wr_en),
    .wr_entry   (upd_wr_entry),
    .row_joint  (row_joint),
    .row_weight (row_weight)
  );

  sws_outbuf #(
    .KEEP (KEEP)
  ) u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .ctl        (buf_ctl),
    .row_joint  (row_joint),
    .row_weight (row_weight),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_vertex (out_vertex),
    .slot       (slot),
    .out_joint  (out_joint),
    .out_weight (out_weight),
    .last       (last)
  );

endmodule

// ===== rtl/sws_checker.sv =====
`include "assert_macros.svh"

module sws_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            operation,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sws_pkg::VW-1:0]          out_vertex,
  input logic [sws_pkg::SLW-1:0]         slot,
  input logic signed [sws_pkg::OJW-1:0]  out_joint,
  input logic [sws_pkg::WW-1:0]          out_weight,
  input logic                            last
);
  import sws_pkg::*;

  // a stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_vertex) && $stable(slot) && $stable(out_joint) && $stable(out_weight))

  // slots of one readout follow each other for the same vertex
  `ASSERT_NEXT(a_slot_seq, clk, rst, out_valid && out_ready && !last, out_valid && slot == $past(slot) + 2'd1 && out_vertex == $past(out_vertex))

  // an empty slot carries no weight
  `ASSERT_IMPLY(a_empty_zero, clk, rst, out_valid && out_joint == JOINT_EMPTY, out_weight == '0)

  // a taken readout word shows results after the memory read and the output buffer load
  `ASSERT_NEXT(a_read_lat, clk, rst, in_valid && in_ready && operation == OP_READ, ##1 out_valid)

endmodule

bind skin_weight_top4_select sws_checker u_chk (.*);
